@@ hdl/adf_pkg.sv @@
package adf_pkg;

  localparam int MaxDataBytesDef = 8;

  // Configuration register indexes
  localparam int CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CFG_START_BYTE     = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_ID_END_BYTE    = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_SEPARATOR_BYTE = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_END_BYTE       = 8'd3;

  localparam logic [7:0] START_BYTE_RST     = 8'd60;
  localparam logic [7:0] ID_END_BYTE_RST    = 8'd58;
  localparam logic [7:0] SEPARATOR_BYTE_RST = 8'd44;
  localparam logic [7:0] END_BYTE_RST       = 8'd62;

  localparam logic [7:0] ASCII_ZERO = 8'h30;

  // Emission steps, in stream order; one bit each in a job's step mask
  localparam int NumSteps  = 6;
  localparam int STEP_START = 0;
  localparam int STEP_HUND  = 1;
  localparam int STEP_TENS  = 2;
  localparam int STEP_ONES  = 3;
  localparam int STEP_IDEND = 4;
  localparam int STEP_TAIL  = 5;

  localparam logic REQ_HEADER = 1'b0;
  localparam logic REQ_DATA   = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] value;
    logic       last;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       frame_end;
  } out_rsp_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] id_end_byte;
    logic [7:0] separator_byte;
    logic [7:0] end_byte;
  } cfg_t;

  // One classified item: which steps to emit and the decimal digits
  typedef struct packed {
    logic [NumSteps-1:0] steps;
    logic [3:0]          hund;
    logic [3:0]          tens;
    logic [3:0]          ones;
    logic                tail_end;
  } job_t;

endpackage

@@ hdl/adf_front.sv @@
module adf_front #(
  parameter int MaxDataBytes = adf_pkg::MaxDataBytesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  adf_pkg::in_req_t in_req_i,
  output logic            push_o,
  output adf_pkg::job_t   job_o,
  input  logic            full_i
);
  import adf_pkg::*;

  localparam int CntW = $clog2(MaxDataBytes + 1);

  logic            open_q, open_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept;
  logic [1:0]      hund;
  logic [6:0]      rem;
  logic [14:0]     tens_prod;
  logic [3:0]      tens;
  logic [6:0]      ones;
  logic [NumSteps-1:0] digit_steps;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  // Decimal split: compare-subtract for hundreds, reciprocal for tens
  always_comb begin
    if (in_req_i.value >= 8'd200) begin
      hund = 2'd2;
      rem  = 7'(in_req_i.value - 8'd200);
    end else if (in_req_i.value >= 8'd100) begin
      hund = 2'd1;
      rem  = 7'(in_req_i.value - 8'd100);
    end else begin
      hund = 2'd0;
      rem  = in_req_i.value[6:0];
    end
    tens_prod = 15'(rem) * 15'd205;
    tens      = tens_prod[14:11];
    ones      = 7'(rem - 7'(tens) * 7'd10);
    digit_steps = '0;
    digit_steps[STEP_ONES] = 1'b1;
    digit_steps[STEP_HUND] = (hund != 2'd0);
    digit_steps[STEP_TENS] = (hund != 2'd0) || (tens != 4'd0);
  end

  always_comb begin
    open_d = open_q;
    cnt_d  = cnt_q;
    push_o = 1'b0;
    job_o.steps    = '0;
    job_o.hund     = {2'b00, hund};
    job_o.tens     = tens;
    job_o.ones     = ones[3:0];
    job_o.tail_end = in_req_i.last;
    if (accept) begin
      if (in_req_i.req_type == REQ_HEADER) begin
        push_o = 1'b1;
        job_o.steps = digit_steps;
        job_o.steps[STEP_START] = 1'b1;
        job_o.steps[STEP_IDEND] = 1'b1;
        job_o.steps[STEP_TAIL]  = in_req_i.last;
        open_d = !in_req_i.last;
        cnt_d  = '0;
      end else if (open_q) begin
        if (cnt_q < CntW'(MaxDataBytes)) begin
          push_o = 1'b1;
          job_o.steps = digit_steps;
          job_o.steps[STEP_TAIL] = 1'b1;
          if (in_req_i.last) begin
            open_d = 1'b0;
            cnt_d  = '0;
          end else begin
            cnt_d = cnt_q + CntW'(1);
          end
        end else if (in_req_i.last) begin
          // over the limit: only the closing byte
          push_o = 1'b1;
          job_o.steps[STEP_TAIL] = 1'b1;
          open_d = 1'b0;
          cnt_d  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      open_q <= open_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

@@ hdl/adf_queue.sv @@
module adf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  adf_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output adf_pkg::job_t pop_job_o
);
  import adf_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o    = (cnt_q == 2'd2);
  assign valid_o   = (cnt_q != 2'd0);
  assign pop_job_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

@@ hdl/adf_back.sv @@
module adf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  adf_pkg::cfg_t    cfg_i,
  input  logic             q_valid_i,
  input  adf_pkg::job_t    q_job_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output adf_pkg::out_rsp_t out_rsp_o
);
  import adf_pkg::*;

  job_t                cur_q;
  logic [NumSteps-1:0] low_bit, rem;
  logic                adv, need_load;
  logic                out_valid_q;
  out_rsp_t            rsp_q, rsp_d;

  assign low_bit   = cur_q.steps & (~cur_q.steps + 1'b1);
  assign rem       = cur_q.steps & ~low_bit;
  assign adv       = !out_valid_q || !out_stall_i;
  assign need_load = (cur_q.steps == '0) || (adv && rem == '0);
  assign q_pop_o   = need_load && q_valid_i;

  always_comb begin
    rsp_d.out_byte    = cfg_i.end_byte;
    rsp_d.frame_end   = 1'b0;
    rsp_d.last_of_run = (rem == '0);
    priority if (low_bit[STEP_START]) begin
      rsp_d.out_byte = cfg_i.start_byte;
    end else if (low_bit[STEP_HUND]) begin
      rsp_d.out_byte = ASCII_ZERO + {4'b0000, cur_q.hund};
    end else if (low_bit[STEP_TENS]) begin
      rsp_d.out_byte = ASCII_ZERO + {4'b0000, cur_q.tens};
    end else if (low_bit[STEP_ONES]) begin
      rsp_d.out_byte = ASCII_ZERO + {4'b0000, cur_q.ones};
    end else if (low_bit[STEP_IDEND]) begin
      rsp_d.out_byte = cfg_i.id_end_byte;
    end else begin
      rsp_d.out_byte  = cur_q.tail_end ? cfg_i.end_byte : cfg_i.separator_byte;
      rsp_d.frame_end = cur_q.tail_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        cur_q <= q_job_i;
      end else if (adv) begin
        cur_q.steps <= rem;
      end
      if (adv) begin
        out_valid_q <= (cur_q.steps != '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

@@ hdl/ascii_decimal_message_framer.sv @@
// Framed ASCII encoder: each accepted request becomes zero to six output bytes,
// delivered one per clock while the output is not stalled. A header request
// gives start byte, its ID in decimal without leading zeros, the ID-end byte
// and, if marked last, the end byte; a data request gives its value in decimal
// followed by the separator or, if last, the end byte. Data outside an open
// message, and data beyond MaxDataBytes that is not last, give nothing.
// The front end classifies a request combinationally and pushes a job into a
// two-entry queue; the back end walks the job's steps at one byte per cycle
// while the output is not stalled, so sustained rate is set by the output, and
// the input stalls only when the queue holds two pending jobs. Requests that
// produce nothing push no job.
// Config writes are always taken (cfg_ready_o is tied high); unknown indexes
// are ignored. Write config only while the block is idle.
module ascii_decimal_message_framer #(
  parameter int MaxDataBytes = adf_pkg::MaxDataBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  adf_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output adf_pkg::out_rsp_t out_rsp_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [adf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]        cfg_data_i
);
  import adf_pkg::*;

  cfg_t cfg_q;
  logic push, full, pop, q_valid;
  job_t push_job, pop_job;

  assign cfg_ready_o = 1'b1;

  // marker byte registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte     <= START_BYTE_RST;
      cfg_q.id_end_byte    <= ID_END_BYTE_RST;
      cfg_q.separator_byte <= SEPARATOR_BYTE_RST;
      cfg_q.end_byte       <= END_BYTE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_START_BYTE:     cfg_q.start_byte     <= cfg_data_i;
        CFG_ID_END_BYTE:    cfg_q.id_end_byte    <= cfg_data_i;
        CFG_SEPARATOR_BYTE: cfg_q.separator_byte <= cfg_data_i;
        CFG_END_BYTE:       cfg_q.end_byte       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front end: message state, decimal split, job build
  adf_front #(.MaxDataBytes(MaxDataBytes)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .push_o     (push),
    .job_o      (push_job),
    .full_i     (full)
  );

  adf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_job_o  (pop_job)
  );

  // back end: step sequencer and output register
  adf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_job_i     (pop_job),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
